@@ src/masd_pkg.sv @@
// Package with the shared constants, types and helpers of the step detector.
`timescale 1ns / 1ps

package masd_pkg;

    // Number of samples in the averaging ring (range 1 to 64).
    localparam int WINDOW_LENGTH = 5;

    localparam int SAMPLE_W = 16;
    localparam int SLOT_W   = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    // Exact window sum: one sign bit plus growth for the ring length.
    localparam int SUM_W    = SAMPLE_W + 1 + $clog2(WINDOW_LENGTH);
    // Comparison width, wide enough for the sum, the 18-bit threshold and
    // the scaled previous sample.
    localparam int CMP_W    = SUM_W + 3;

    localparam int THRESH_W = 18;
    localparam int EVENTS_W = 4;
    localparam int STEP_W   = 16;
    localparam int CFG_W    = 18;
    localparam int CFG_IDX_W = 1;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 18'd86016;
    localparam logic [EVENTS_W-1:0] EVENTS_RESET = 4'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_THRESHOLD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENTS_PER_STEP = 1'b1;

    typedef logic [SLOT_W-1:0]          t_slot;
    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Write request from the update stage into the sample ring.
    typedef struct packed {
        logic    en;
        t_slot   slot;
        t_sample data;
    } t_ring_wr;

    // Next ring slot, wrapping after the last entry.
    function automatic t_slot next_slot(input t_slot slot);
        t_slot result;
        if (slot == SLOT_W'(WINDOW_LENGTH - 1)) begin
            result = '0;
        end else begin
            result = slot + SLOT_W'(1);
        end
        return result;
    endfunction

endpackage

@@ src/masd_ring.sv @@
// Sample ring memory with cleared-at-reset entries and write-to-read forwarding.
`timescale 1ns / 1ps

module masd_ring
    import masd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_rd_en,
    input  t_slot    i_rd_slot,
    input  t_ring_wr i_wr,
    output t_sample  o_rd_data
);

    t_sample                  r_mem [WINDOW_LENGTH];
    logic [WINDOW_LENGTH-1:0] r_valid;
    t_sample                  r_rd_mem;
    logic                     r_rd_ok;
    logic                     r_fwd;
    t_sample                  r_fwd_data;

    // Synchronous memory: one write and one read port, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.slot] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_mem <= r_mem[i_rd_slot];
        end
    end

    // An entry never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.slot] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_valid[i_rd_slot];
                r_fwd   <= i_wr.en && (i_wr.slot == i_rd_slot);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr.data;
        end
    end

    always_comb begin
        if (r_fwd) begin
            o_rd_data = r_fwd_data;
        end else if (r_rd_ok) begin
            o_rd_data = r_rd_mem;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

@@ src/moving_average_step_detector.sv @@
// Top level of the moving-average step detector.
`timescale 1ns / 1ps
// The result of an accepted request passes through the update stage and then
// the output register, where it waits for i_ready. Throughput: one request per
// cycle while the output drains; the ring memory is read at acceptance and
// written back as the update stage moves on, so the read-modify-write of the
// window sum sets the pace. A depth-one ring is served by forwarding.
// Reset (synchronous, active low) empties the pipeline, zeroes the sum, tallies
// and previous sample, marks every ring entry as zero and loads the register
// defaults. No clearing pass is needed; requests are taken right after reset.

module moving_average_step_detector
    import masd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [15:0]   i_accel_sample,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [15:0]          o_step_total,
    output logic                 o_step_seen,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    // Configuration registers.
    logic [THRESH_W-1:0] r_sum_threshold;
    logic [EVENTS_W-1:0] r_events_per_step;

    // Read stage pointer: the slot the next accepted sample will replace.
    t_slot r_rd_slot;

    // Update stage: the sample whose old ring entry is being read.
    logic    r_s1_vld;
    t_sample r_s1_sample;
    t_slot   r_s1_slot;

    // Running state kept next to the ring.
    logic signed [SUM_W-1:0] r_sum;
    t_sample                 r_last;
    logic [EVENTS_W-1:0]     r_event_tally;
    logic [STEP_W-1:0]       r_step_tally;

    // Output register.
    logic              r_out_vld;
    logic [STEP_W-1:0] r_out_total;
    logic              r_out_seen;

    logic     in_acc;
    logic     s1_adv;
    t_sample  old_sample;
    t_ring_wr ring_wr;

    logic signed [SUM_W-1:0] n_sum;
    logic signed [CMP_W-1:0] sum_ext;
    logic signed [CMP_W-1:0] thresh_ext;
    logic signed [CMP_W-1:0] last_scaled;
    logic                    is_event;
    logic [EVENTS_W-1:0]     tally_inc;
    logic [EVENTS_W-1:0]     need;
    logic                    step_hit;
    logic [EVENTS_W-1:0]     n_event_tally;
    logic [STEP_W-1:0]       n_step_tally;

    // The update stage moves on when the output register is empty or drained.
    // A new request is taken whenever the update stage is free or moving on,
    // so one request can still enter behind a waiting result; a second one
    // is held off until that result is taken.
    assign s1_adv  = r_s1_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_s1_vld || s1_adv;
    assign in_acc  = i_valid && o_ready;

    // The update stage writes the new sample back over the entry it replaced.
    assign ring_wr.en   = s1_adv;
    assign ring_wr.slot = r_s1_slot;
    assign ring_wr.data = r_s1_sample;

    masd_ring u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_slot (r_rd_slot),
        .i_wr      (ring_wr),
        .o_rd_data (old_sample)
    );

    // Window arithmetic. The average test compares the sum against the
    // previous sample scaled by the window length, so nothing is divided.
    always_comb begin
        n_sum = r_sum - SUM_W'(old_sample) + SUM_W'(r_s1_sample);
        sum_ext     = CMP_W'(n_sum);
        thresh_ext  = $signed({{(CMP_W-THRESH_W){1'b0}}, r_sum_threshold});
        last_scaled = CMP_W'(r_last) * CMP_W'(WINDOW_LENGTH);

        is_event = (sum_ext > thresh_ext) && (r_s1_sample > r_last) &&
                   (sum_ext < last_scaled);

        tally_inc = is_event ? (r_event_tally + EVENTS_W'(1)) : r_event_tally;
        // A zero requirement behaves like one event per step.
        need      = (r_events_per_step == '0) ? EVENTS_W'(1) : r_events_per_step;
        // A requirement lowered under the current tally still fires here.
        step_hit  = (tally_inc >= need);

        n_event_tally = step_hit ? '0 : tally_inc;
        n_step_tally  = step_hit ? (r_step_tally + STEP_W'(1)) : r_step_tally;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_threshold   <= THRESH_RESET;
            r_events_per_step <= EVENTS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SUM_THRESHOLD: begin
                    r_sum_threshold <= i_cfg_wdata[THRESH_W-1:0];
                end
                CFG_EVENTS_PER_STEP: begin
                    r_events_per_step <= i_cfg_wdata[EVENTS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Pipeline control and running state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_slot     <= '0;
            r_s1_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_sum         <= '0;
            r_last        <= '0;
            r_event_tally <= '0;
            r_step_tally  <= '0;
        end else begin
            if (in_acc) begin
                r_rd_slot <= next_slot(r_rd_slot);
                r_s1_vld  <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld  <= 1'b0;
            end

            if (s1_adv) begin
                r_out_vld     <= 1'b1;
                r_sum         <= n_sum;
                r_last        <= r_s1_sample;
                r_event_tally <= n_event_tally;
                r_step_tally  <= n_step_tally;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_sample <= i_accel_sample;
            r_s1_slot   <= r_rd_slot;
        end
        if (s1_adv) begin
            r_out_total <= n_step_tally;
            r_out_seen  <= step_hit;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_step_total = r_out_total;
    assign o_step_seen  = r_out_seen;

    // The read pointer always runs exactly one slot ahead of the update stage.
    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (r_rd_slot == next_slot(r_s1_slot)))
        else $error("read slot is not one ahead of the update stage");

    // A step moves the step tally by exactly one and clears the event tally.
    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && step_hit) |=>
            (r_step_tally == $past(r_step_tally) + STEP_W'(1)) &&
            (r_event_tally == '0) && r_out_seen)
        else $error("step did not advance the tally by one");

    // After an update the event tally stays below the requirement.
    a_tally_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> ((r_events_per_step == '0) ? (r_event_tally == '0)
                                               : (r_event_tally < r_events_per_step)))
        else $error("event tally reached the requirement without a step");

    // While a result is valid, the published total matches the running step tally.
    a_total_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_total == r_step_tally))
        else $error("output total differs from the step tally");

endmodule

@@ verif/moving_average_step_detector_test.sv @@
// Self-checking testbench for the moving-average step detector.
`timescale 1ns / 1ps

module moving_average_step_detector_test;
    import masd_pkg::*;

    // Quiet cycles (no request moving on any port) before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles allowed after the last result for stray output to show up.
    localparam int SETTLE_CYCLES  = 8;
    // Random samples per configuration chunk, and the number of chunks.
    localparam int CHUNK_ITEMS    = 165;
    localparam int CHUNK_COUNT    = 10;

    typedef struct packed {
        logic [STEP_W-1:0] total;
        logic              seen;
    } t_step_result;

    // Every input of the block starts at a known value.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic signed [15:0]   i_accel_sample = '0;
    logic                 i_ready     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 o_ready;
    logic                 o_valid;
    logic [15:0]          o_step_total;
    logic                 o_step_seen;

    moving_average_step_detector u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_accel_sample (i_accel_sample),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_step_total   (o_step_total),
        .o_step_seen    (o_step_seen),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Samples waiting to be offered, and step counts predicted for requests
    // already taken by the block, oldest first.
    t_sample      sample_backlog[$];
    t_step_result expected_counts[$];

    // Idle percentages of the sample sender and the result receiver.
    int send_gap_pct = 37;
    int recv_gap_pct = 71;

    // Private copy of the detector state and its two registers.
    t_sample             ring_copy [WINDOW_LENGTH];
    int                  ring_pos;
    int                  ring_total;
    t_sample             prev_accel;
    logic [EVENTS_W-1:0] event_run;
    logic [STEP_W-1:0]   step_run;
    logic [THRESH_W-1:0] cfg_threshold;
    logic [EVENTS_W-1:0] cfg_events;

    logic in_taken = 1'b0;
    int   quiet_cycles = 0;
    int   fault_count = 0;
    int   samples_taken = 0;
    int   results_checked = 0;
    int   steps_observed = 0;
    int   wrap_count = 0;
    int   writes_done = 0;

    // Advance the private copy by one sample and return the step count and
    // step flag that the block must report for it. The sum and the scaled
    // previous sample are compared exactly, with no division.
    function automatic t_step_result model_step_count(input t_sample accel);
        t_step_result        res;
        logic [EVENTS_W-1:0] need;
        ring_total = ring_total - int'(ring_copy[ring_pos]) + int'(accel);
        ring_copy[ring_pos] = accel;
        ring_pos = (ring_pos == WINDOW_LENGTH - 1) ? 0 : ring_pos + 1;
        if (ring_total > int'(cfg_threshold) && accel > prev_accel &&
            ring_total < WINDOW_LENGTH * int'(prev_accel)) begin
            event_run = event_run + 1'b1;
        end
        // A zero requirement behaves as one. A requirement lowered below the
        // running tally fires on the next sample whether or not it is an event.
        need = (cfg_events == '0) ? EVENTS_W'(1) : cfg_events;
        res.seen = 1'b0;
        if (event_run >= need) begin
            if (step_run == '1) begin
                wrap_count++;
            end
            step_run = step_run + 1'b1;
            event_run = '0;
            res.seen = 1'b1;
        end
        prev_accel = accel;
        res.total = step_run;
        return res;
    endfunction

    task automatic count_fault(input string detail);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t ns: %s", $time, detail);
        end
    endtask

    // Sample driver: a request stays up with its sample unchanged until it is
    // taken; a new one is offered only after the previous one went through.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_accel_sample <= '0;
        end else if (!i_valid || in_taken) begin
            if (sample_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                i_valid <= 1'b1;
                i_accel_sample <= sample_backlog.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result receiver: back-pressure at random.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Monitor: mirrors register writes, predicts each taken sample and checks
    // each delivered result against the oldest prediction. Predictions are
    // pushed before results are popped so the order holds at any latency.
    always @(posedge i_clk) begin
        t_step_result want;
        in_taken <= i_valid && o_ready;
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_LENGTH; k++) begin
                ring_copy[k] = '0;
            end
            ring_pos = 0;
            ring_total = 0;
            prev_accel = '0;
            event_run = '0;
            step_run = '0;
            cfg_threshold = THRESH_RESET;
            cfg_events = EVENTS_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SUM_THRESHOLD:   cfg_threshold = i_cfg_wdata[THRESH_W-1:0];
                    CFG_EVENTS_PER_STEP: cfg_events = i_cfg_wdata[EVENTS_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                expected_counts.push_back(model_step_count(i_accel_sample));
                samples_taken++;
            end
            if (o_valid && i_ready) begin
                results_checked++;
                if (expected_counts.size() == 0) begin
                    count_fault($sformatf("result with nothing expected: step_total %0d",
                                          o_step_total));
                end else begin
                    want = expected_counts.pop_front();
                    if (want.seen) begin
                        steps_observed++;
                    end
                    if (o_step_total !== want.total) begin
                        count_fault($sformatf("step_total expected %0d, got %0d",
                                              want.total, o_step_total));
                    end
                    if (o_step_seen !== want.seen) begin
                        count_fault($sformatf("step_seen expected %0b, got %0b",
                                              want.seen, o_step_seen));
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Registers are only touched while the block holds no work.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        writes_done++;
    endtask

    // Waits until every sample is taken and every result is back.
    task automatic wait_for_idle();
        while (sample_backlog.size() != 0 || i_valid || expected_counts.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // One stride of a walking waveform: a rise from base by amp over half
    // samples and the fall back, with a little jitter. A cut shorter than the
    // stride leaves a broken stride behind.
    function automatic void queue_stride(input int base, input int amp,
                                         input int half, input int cut);
        int lvl;
        for (int k = 0; k <= 2 * half && k < cut; k++) begin
            lvl = (k <= half) ? base + amp * k / half : base + amp * (2 * half - k) / half;
            lvl = lvl + $urandom_range(400) - 200;
            if (lvl > 32767) begin
                lvl = 32767;
            end else if (lvl < -32768) begin
                lvl = -32768;
            end
            sample_backlog.push_back(t_sample'(lvl));
        end
    endfunction

    initial begin
        int                  pick;
        int                  half;
        logic [CFG_W-1:0]    thr_val;
        logic [EVENTS_W-1:0] evt_val;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset register values first: field extremes and
        // alternating bit patterns from an empty ring.
        sample_backlog.push_back(16'sh7FFF);
        sample_backlog.push_back(16'sh8000);
        sample_backlog.push_back(16'sh5555);
        sample_backlog.push_back(16'shAAAA);
        sample_backlog.push_back(16'shFFFF);
        // A steady climb above 1 g: qualifying events, two per step.
        for (int v = 16000; v <= 30000; v += 2000) begin
            sample_backlog.push_back(t_sample'(v));
        end
        wait_for_idle();

        // Zero events per step behaves as one; no threshold at all.
        write_register(CFG_EVENTS_PER_STEP, '0);
        write_register(CFG_SUM_THRESHOLD, '0);
        for (int v = 2000; v <= 12000; v += 2000) begin
            sample_backlog.push_back(t_sample'(v));
        end
        wait_for_idle();

        // Build up a tally under the largest requirement, then lower the
        // requirement below it: the next sample counts a step although it falls.
        write_register(CFG_EVENTS_PER_STEP, CFG_W'(15));
        for (int v = 14000; v <= 24000; v += 2000) begin
            sample_backlog.push_back(t_sample'(v));
        end
        wait_for_idle();
        write_register(CFG_EVENTS_PER_STEP, CFG_W'(1));
        sample_backlog.push_back('0);
        wait_for_idle();

        // Random part: a new pair of register values per chunk, the idle
        // pattern switching from sender-light to receiver-light to none.
        for (int chunk = 0; chunk < CHUNK_COUNT; chunk++) begin
            if (chunk == 4) begin
                send_gap_pct = 71;
                recv_gap_pct = 37;
            end else if (chunk == 8) begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            case (chunk)
                0, 9:    thr_val = '0;
                1:       thr_val = CFG_W'(163835);
                2, 7:    thr_val = CFG_W'(THRESH_RESET);
                4:       thr_val = '1;
                5:       thr_val = CFG_W'(1);
                default: thr_val = CFG_W'($urandom_range(163835));
            endcase
            case (chunk)
                0, 7:    evt_val = 4'd1;
                1, 5:    evt_val = 4'd15;
                2:       evt_val = 4'd0;
                4:       evt_val = 4'd2;
                9:       evt_val = 4'd3;
                default: evt_val = 4'($urandom_range(15));
            endcase
            write_register(CFG_SUM_THRESHOLD, thr_val);
            // Upper data bits are junk; only the low nibble must land.
            write_register(CFG_EVENTS_PER_STEP, {14'($urandom()), evt_val});

            // Mostly whole strides with random shape, some cut short, some
            // bursts of full-range noise.
            while (sample_backlog.size() < CHUNK_ITEMS) begin
                pick = $urandom_range(99);
                half = $urandom_range(1, 8);
                if (pick < 70) begin
                    queue_stride($urandom_range(30000) - 6000, $urandom_range(16000), half,
                                 2 * half + 1);
                end else if (pick < 85) begin
                    queue_stride($urandom_range(30000) - 6000, $urandom_range(16000), half,
                                 $urandom_range(1, half));
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        sample_backlog.push_back(t_sample'($urandom()));
                    end
                end
            end
            wait_for_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_counts.size() != 0) begin
            count_fault($sformatf("%0d results never arrived", expected_counts.size()));
        end
        $display("Covered %0d samples and %0d results over %0d register writes,",
                 samples_taken, results_checked, writes_done);
        $display("with %0d completed steps, %0d step counter wraps and %0d faults.",
                 steps_observed, wrap_count, fault_count);
        if (fault_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
